// ----- design/wlps_pkg.sv -----
// Package for the warning LED pattern sequencer.
// Holds the pattern mode codes, the step delays, the register map and the
// pattern state type. It depends on nothing else.
package wlps_pkg;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned MODE_W  = 3;
	localparam int unsigned COUNT_W = 8;
	localparam int unsigned DELAY_W = 20;

	localparam logic [MODE_W-1:0] MODE_OFF   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ON    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_FLASH = 3'd2;
	localparam logic [MODE_W-1:0] MODE_PULSE = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CODE  = 3'd4;

	localparam logic [DELAY_W-1:0] DELAY_DEFAULT  = 20'd500000;
	localparam logic [DELAY_W-1:0] DELAY_SHORT_ON = 20'd200000;
	localparam logic [DELAY_W-1:0] DELAY_LONG_OFF = 20'd900000;
	localparam logic [DELAY_W-1:0] DELAY_BLINK    = 20'd100000;

	// Register index, taken from address bit 2.
	localparam logic REG_REQUESTED_MODE = 1'b0;
	localparam logic REG_BLINK_CODE     = 1'b1;

	typedef struct packed {
		logic [TIME_W-1:0]  deadline;
		logic [MODE_W-1:0]  active_mode;
		logic               lamp_level;
		logic [COUNT_W-1:0] blink_count;
		logic               pattern_done;
	} pattern_state_t;

endpackage

// ----- design/wlps_step.sv -----
// Next-state logic of the warning LED pattern sequencer.
// Computes one refresh from the current pattern state and a timestamp.
// Depends on wlps_pkg.
module wlps_step
	import wlps_pkg::*;
(
	input  pattern_state_t     cur,
	input  logic [MODE_W-1:0]  requested_mode,
	input  logic [COUNT_W-1:0] blink_code,
	input  logic [TIME_W-1:0]  now_us,
	output pattern_state_t     nxt,
	output logic               refresh
);

	logic [TIME_W-1:0]  diff;
	logic [MODE_W-1:0]  wanted;
	logic [MODE_W-1:0]  mode;
	logic               lamp;
	logic               done;
	logic [COUNT_W-1:0] cnt;
	logic [DELAY_W-1:0] delay;

	assign diff    = now_us - cur.deadline;
	// The deadline counts as passed when the wrapped difference is not negative.
	assign refresh = ~diff[TIME_W-1];
	assign wanted  = (requested_mode > MODE_CODE) ? MODE_OFF : requested_mode;

	always_comb begin
		mode  = cur.active_mode;
		lamp  = cur.lamp_level;
		done  = cur.pattern_done;
		cnt   = cur.blink_count;
		delay = DELAY_DEFAULT;

		// A new mode is taken only once the running pattern has finished.
		if (wanted != mode && done) begin
			lamp = 1'b0;
			mode = wanted;
			done = 1'b0;
		end

		case (mode)
			MODE_ON: begin
				lamp = 1'b1;
				done = 1'b1;
			end
			MODE_FLASH: begin
				lamp = ~lamp;
				if (!lamp)
					done = 1'b1;
			end
			MODE_PULSE: begin
				lamp = ~lamp;
				if (lamp) begin
					delay = DELAY_SHORT_ON;
					done  = 1'b0;
				end else begin
					delay = DELAY_LONG_OFF;
					done  = 1'b1;
				end
			end
			MODE_CODE: begin
				lamp = ~lamp;
				done = 1'b0;
				if (!lamp) begin
					if (cnt != '0)
						cnt = cnt - 1'b1;
					// End of a series: long gap and reload from the code register.
					if (cnt == '0) begin
						done = 1'b1;
						cnt  = blink_code;
					end
				end
				delay = done ? DELAY_LONG_OFF : DELAY_BLINK;
			end
			default: begin
				lamp = 1'b0;
				done = 1'b1;
			end
		endcase

		nxt.deadline     = now_us + {{(TIME_W-DELAY_W){1'b0}}, delay};
		nxt.active_mode  = mode;
		nxt.lamp_level   = lamp;
		nxt.blink_count  = cnt;
		nxt.pattern_done = done;
	end

endmodule

// ----- design/warning_led_pattern_sequencer_core.sv -----
// Top level of the warning LED pattern sequencer.
// Holds the input register, pattern state, result register and APB registers.
// Depends on wlps_pkg and wlps_step.
//
// Usage: each input transaction on in_valid/in_stall carries now_us, the
// current free-running microsecond time. Every input transaction yields
// exactly one output transaction on out_valid/out_stall with led_on, the LED
// level after that timestamp, and refreshed, set when the deadline had been
// reached and the pattern advanced.
// Each stamp passes the input register, then the pattern update writes the
// state and the result register at the same edge. Throughput is one
// transaction per cycle while out_stall is low; the critical path is the
// mode logic that picks the step delay, feeding the 32-bit deadline add.
// While out_stall is high and a result is waiting, one more transaction is
// held in the input register; after that in_stall rises. Nothing is dropped.
// Reset clears the pattern state (mode off, lamp dark, pattern finished,
// deadline zero) and both configuration registers. requested_mode sits at
// address 0 and blink_code at address 4; writes take effect immediately.
module warning_led_pattern_sequencer_core
	import wlps_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [TIME_W-1:0] now_us,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              led_on,
	output logic              refreshed,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [MODE_W-1:0]  requested_mode_q;
	logic [COUNT_W-1:0] blink_code_q;
	logic               reg_index;

	logic               valid_s1;
	logic [TIME_W-1:0]  now_s1;
	logic               advance;
	logic               fire;

	pattern_state_t     state_q;
	pattern_state_t     state_nxt;
	logic               refresh;

	logic               out_valid_q;
	logic               led_on_q;
	logic               refreshed_q;

	assign pready    = 1'b1;
	assign reg_index = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			requested_mode_q <= MODE_OFF;
			blink_code_q     <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_index)
				REG_REQUESTED_MODE: requested_mode_q <= pwdata[MODE_W-1:0];
				REG_BLINK_CODE:     blink_code_q     <= pwdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_index)
			REG_REQUESTED_MODE: prdata = {{(32-MODE_W){1'b0}}, requested_mode_q};
			REG_BLINK_CODE:     prdata = {{(32-COUNT_W){1'b0}}, blink_code_q};
			default:            prdata = '0;
		endcase
	end

	// The result register can take a new result when empty or being drained.
	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			now_s1 <= now_us;
	end

	wlps_step u_step (
		.cur            (state_q),
		.requested_mode (requested_mode_q),
		.blink_code     (blink_code_q),
		.now_us         (now_s1),
		.nxt            (state_nxt),
		.refresh        (refresh)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.deadline     <= '0;
			state_q.active_mode  <= MODE_OFF;
			state_q.lamp_level   <= 1'b0;
			state_q.blink_count  <= '0;
			state_q.pattern_done <= 1'b1;
		end else if (fire && refresh) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			led_on_q    <= refresh ? state_nxt.lamp_level : state_q.lamp_level;
			refreshed_q <= refresh;
		end
	end

	assign out_valid = out_valid_q;
	assign led_on    = led_on_q;
	assign refreshed = refreshed_q;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for warning_led_pattern_sequencer_core: drives timestamp
// transactions and APB register writes, and predicts the LED level per stamp.
// Depends on wlps_pkg and the core RTL.
module tb_top
	import wlps_pkg::*;
();

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [TIME_W-1:0] now_us;
	logic              out_valid;
	logic              out_stall;
	logic              led_on;
	logic              refreshed;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [2:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	typedef struct packed {
		logic led_on;
		logic refreshed;
	} lamp_result_t;

	class lamp_scoreboard;
		pattern_state_t     st;
		logic [MODE_W-1:0]  mode_reg;
		logic [COUNT_W-1:0] code_reg;
		lamp_result_t       expected_q[$];
		int unsigned        mismatches;

		function new();
			st.deadline     = '0;
			st.active_mode  = MODE_OFF;
			st.lamp_level   = 1'b0;
			st.blink_count  = '0;
			st.pattern_done = 1'b1;
			mode_reg        = MODE_OFF;
			code_reg        = '0;
			mismatches      = 0;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		task report_mismatch(input string msg);
			$display("MISMATCH @%0t: %s", $time, msg);
			mismatches++;
		endtask

		// One refresh of the pattern; returns the delay to the next deadline.
		function logic [DELAY_W-1:0] advance_lamp();
			logic [MODE_W-1:0]  wanted;
			logic [DELAY_W-1:0] delay;
			wanted = (mode_reg > MODE_CODE) ? MODE_OFF : mode_reg;
			delay  = DELAY_DEFAULT;
			// A new mode is only picked up once the running pattern has finished.
			if (wanted != st.active_mode && st.pattern_done) begin
				st.lamp_level   = 1'b0;
				st.active_mode  = wanted;
				st.pattern_done = 1'b0;
			end
			case (st.active_mode)
				MODE_ON: begin
					st.lamp_level   = 1'b1;
					st.pattern_done = 1'b1;
				end
				MODE_FLASH: begin
					st.lamp_level = ~st.lamp_level;
					if (!st.lamp_level)
						st.pattern_done = 1'b1;
				end
				MODE_PULSE: begin
					st.lamp_level   = ~st.lamp_level;
					st.pattern_done = ~st.lamp_level;
					delay = st.lamp_level ? DELAY_SHORT_ON : DELAY_LONG_OFF;
				end
				MODE_CODE: begin
					st.lamp_level   = ~st.lamp_level;
					st.pattern_done = 1'b0;
					if (!st.lamp_level) begin
						if (st.blink_count != '0)
							st.blink_count--;
						if (st.blink_count == '0) begin
							st.pattern_done = 1'b1;
							st.blink_count  = code_reg;
						end
					end
					delay = st.pattern_done ? DELAY_LONG_OFF : DELAY_BLINK;
				end
				default: begin
					st.lamp_level   = 1'b0;
					st.pattern_done = 1'b1;
				end
			endcase
			return delay;
		endfunction

		function void note_input(input logic [TIME_W-1:0] stamp);
			logic [TIME_W-1:0] since;
			logic [TIME_W-1:0] step;
			lamp_result_t      want;
			since          = stamp - st.deadline;
			want.refreshed = 1'b0;
			// The deadline counts as reached when the wrapped difference is not negative.
			if (!since[TIME_W-1]) begin
				step           = {{(TIME_W-DELAY_W){1'b0}}, advance_lamp()};
				st.deadline    = stamp + step;
				want.refreshed = 1'b1;
			end
			want.led_on = st.lamp_level;
			expected_q.push_back(want);
		endfunction

		task check_result(input logic led, input logic refr);
			lamp_result_t want;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result led_on=%0b refreshed=%0b",
					led, refr));
				return;
			end
			want = expected_q.pop_front();
			if (led !== want.led_on)
				report_mismatch($sformatf("led_on %b, expected %b", led, want.led_on));
			if (refr !== want.refreshed)
				report_mismatch($sformatf("refreshed %b, expected %b", refr,
					want.refreshed));
		endtask
	endclass

	lamp_scoreboard    sb = new();
	int unsigned       tx_max_gap = 18;
	int unsigned       rx_max_gap = 18;
	bit                long_hold = 1'b0;
	logic [TIME_W-1:0] clock_us = '0;

	warning_led_pattern_sequencer_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.now_us    (now_us),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.led_on    (led_on),
		.refreshed (refreshed),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly a clock that moves forward in steps of up to 150000 us, with hits on
	// the deadline and its neighbor, small steps, and jumps across the whole range.
	function automatic logic [TIME_W-1:0] next_stamp();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			clock_us += $urandom_range(0, 150000);
		else if (pick < 72)
			clock_us = sb.st.deadline;
		else if (pick < 78)
			clock_us = sb.st.deadline - 1;
		else if (pick < 83)
			clock_us = $urandom();
		else if (pick < 86)
			clock_us = 32'hFFFF_FFFF - $urandom_range(0, 1000000);
		else
			clock_us += $urandom_range(0, 20);
		return clock_us;
	endfunction

	task automatic send_stamp(input logic [TIME_W-1:0] stamp);
		int unsigned gap;
		gap = $urandom_range(0, tx_max_gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		now_us   <= stamp;
		do @(posedge clk); while (in_stall);
		sb.note_input(stamp);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_REQUESTED_MODE)
			sb.mode_reg = value[MODE_W-1:0];
		else
			sb.code_reg = value[COUNT_W-1:0];
	endtask

	// Wait until every expected result is back, then let the pipeline drain.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Result side: random stalls per transaction, one long hold on request.
	initial begin
		int unsigned hold;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = long_hold ? 200 : $urandom_range(0, rx_max_gap);
			long_hold = 1'b0;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
			sb.check_result(led_on, refreshed);
		end
	end

	initial begin
		logic [MODE_W-1:0]  dir_modes [7];
		logic [COUNT_W-1:0] dir_codes [7];
		logic [MODE_W-1:0]  mode_sel;
		logic [COUNT_W-1:0] code_sel;
		int unsigned        phase;
		int unsigned        len;
		int unsigned        n_sent;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		now_us   = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		dir_modes = '{MODE_ON, MODE_FLASH, MODE_PULSE, MODE_CODE, MODE_CODE, 3'd5, 3'd7};
		dir_codes = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd2, 8'd0, 8'd0};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: timestamp extremes and sign boundary, then each mode with
		// a stamp just short of the deadline and two on it.
		write_reg(REG_REQUESTED_MODE, {29'd0, MODE_OFF});
		write_reg(REG_BLINK_CODE, 32'd0);
		send_stamp(32'h0000_0000);
		send_stamp(32'hFFFF_FFFF);
		send_stamp(32'h7FFF_FFFF);
		send_stamp(32'h8000_0000);
		settle();
		for (int i = 0; i < 7; i++) begin
			write_reg(REG_REQUESTED_MODE, {29'd0, dir_modes[i]});
			write_reg(REG_BLINK_CODE, {24'd0, dir_codes[i]});
			send_stamp(sb.st.deadline - 1);
			send_stamp(sb.st.deadline);
			send_stamp(sb.st.deadline);
			settle();
		end

		phase  = 0;
		n_sent = 0;
		while (n_sent < 1500) begin
			if (phase < 8)
				mode_sel = phase[2:0];
			else if ($urandom_range(0, 9) < 8)
				mode_sel = MODE_W'($urandom_range(0, 4));
			else
				mode_sel = MODE_W'($urandom_range(5, 7));
			case ($urandom_range(0, 9))
				0:       code_sel = 8'd0;
				1:       code_sel = 8'd255;
				default: code_sel = COUNT_W'($urandom_range(0, 12));
			endcase
			if (phase == 0)
				code_sel = 8'd255;
			if (phase < 8 || $urandom_range(0, 3) != 0)
				write_reg(REG_REQUESTED_MODE, {29'd0, mode_sel});
			if (phase < 2 || $urandom_range(0, 2) == 0)
				write_reg(REG_BLINK_CODE, {24'd0, code_sel});
			if (phase % 4 == 3) begin
				tx_max_gap = 0;
				rx_max_gap = 0;
			end else begin
				tx_max_gap = 18;
				rx_max_gap = 18;
			end
			// Back-to-back stamps against a long result hold fill the pipeline.
			if (phase == 5) begin
				tx_max_gap = 0;
				long_hold  = 1'b1;
			end
			len = $urandom_range(30, 90);
			repeat (len) send_stamp(next_stamp());
			n_sent += len;
			settle();
			phase++;
		end

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
